### design/assert_macros.svh
// Assertion helpers shared by the sparse-table RTL.
// Both forms are clocked on the rising edge and held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMST_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RMST_ASSERT_NEXT(label, clk, rst, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);
`else
`define RMST_ASSERT(label, clk, rst, prop, msg)
`define RMST_ASSERT_NEXT(label, clk, rst, cond, expect_next, msg)
`endif
`endif

### design/rmst_pkg.sv
`default_nettype none

package rmst_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int IDX_W  = 11;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // defaults for the top-level parameters
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEVELS       = 11;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REPLY  = 2'd2
  } cmd_kind_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE    = 3'd0,
    B_APPEND  = 3'd1,
    B_QUERY_A = 3'd2,
    B_QUERY_B = 3'd3,
    B_EMIT    = 3'd4
  } back_state_t;

  // element position width for a table depth
  function automatic int pos_width(int max_elements);
    return (max_elements > 1) ? $clog2(max_elements) : 1;
  endfunction

  // packed command width: kind, status, value, two positions, level
  function automatic int cmd_width(int pos_w, int lvl_w);
    return $bits(cmd_kind_t) + $bits(status_t) + DATA_W + 2 * pos_w + lvl_w;
  endfunction

endpackage

`default_nettype wire

### design/rmst_front.sv
`default_nettype none
`include "assert_macros.svh"

module rmst_front import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEVELS       = DEF_LEVELS,
  localparam int POS_W = pos_width(MAX_ELEMENTS),
  localparam int LVL_W = $clog2(LEVELS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int CMD_W = cmd_width(POS_W, LVL_W)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] value_in,
  input  logic [IDX_W-1:0]         left_index,
  input  logic [IDX_W-1:0]         right_index,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output logic [CMD_W-1:0]         cmd_data
);

  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int KW    = $clog2(IDX_W);

  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [LVL_W-1:0]   lvl;
  } cmd_t;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cmd_t             cmd;
  logic             accept;
  logic             full;
  logic             bad_range;
  logic [IDX_W-1:0] len;
  logic [KW-1:0]    k_raw;
  logic [KW-1:0]    k_cap;
  logic [IDX_W-1:0] span;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && in_ready;
  assign cmd_data  = cmd;

  // range checks
  assign full      = (count == CNT_W'(MAX_ELEMENTS));
  assign bad_range = (left_index == '0) || (right_index < left_index) ||
                     (CMP_W'(right_index) > CMP_W'(count));
  assign len       = right_index - left_index + IDX_W'(1);

  // floor log2 of the range length
  always_comb begin
    k_raw = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (len[i]) begin
        k_raw = KW'(i);
      end
    end
  end

  // level cap
  always_comb begin
    k_cap = k_raw;
    if (int'(k_raw) > LEVELS - 1) begin
      k_cap = KW'(LEVELS - 1);
    end
  end

  assign span = IDX_W'(1) << k_cap;

  // classify the request
  always_comb begin
    cmd        = '0;
    count_next = count;
    case (op_t'(op))
      OP_APPEND: begin
        if (full) begin
          cmd.kind   = CMD_REPLY;
          cmd.status = ST_FULL;
        end else begin
          cmd.kind   = CMD_APPEND;
          cmd.status = ST_OK;
          cmd.value  = value_in;
          cmd.pos_a  = POS_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      OP_QUERY: begin
        if (bad_range) begin
          cmd.kind   = CMD_REPLY;
          cmd.status = ST_BAD_RANGE;
        end else begin
          cmd.kind   = CMD_QUERY;
          cmd.status = ST_OK;
          cmd.pos_a  = POS_W'(left_index - IDX_W'(1));
          cmd.pos_b  = POS_W'(right_index - span);
          cmd.lvl    = LVL_W'(k_cap);
        end
      end
      OP_CLEAR: begin
        cmd.kind   = CMD_REPLY;
        cmd.status = ST_OK;
        count_next = '0;
      end
      default: begin
        cmd.kind   = CMD_REPLY;
        cmd.status = ST_OK;
      end
    endcase
  end

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  `RMST_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_ELEMENTS),
    "element count beyond table depth")
  `RMST_ASSERT_NEXT(a_full_keeps_count, clk, rst,
    accept && op == OP_APPEND && full, count == $past(count),
    "append to full table changed the count")

endmodule

`default_nettype wire

### design/rmst_queue.sv
`default_nettype none

module rmst_queue import rmst_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  entries [DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/rmst_back.sv
`default_nettype none
`include "assert_macros.svh"

module rmst_back import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEVELS       = DEF_LEVELS,
  localparam int POS_W = pos_width(MAX_ELEMENTS),
  localparam int LVL_W = $clog2(LEVELS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int CMD_W = cmd_width(POS_W, LVL_W)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [CMD_W-1:0]         cmd_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] min_value,
  output logic [STAT_W-1:0]        status
);

  localparam int SPAN_W    = ((LEVELS + 1) > CNT_W) ? (LEVELS + 1) : CNT_W;
  localparam int LV1_W     = LVL_W + 1;
  localparam int ADDR_W    = LVL_W + POS_W;
  localparam int MEM_DEPTH = LEVELS * (2 ** POS_W);

  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [LVL_W-1:0]   lvl;
  } cmd_t;

  // window of 2^l elements ending at position p exists inside the table
  function automatic logic level_fits(logic [LV1_W-1:0] l, logic [POS_W-1:0] p);
    return (l < LV1_W'(LEVELS)) &&
           ((SPAN_W'(1) << l) <= (SPAN_W'(p) + SPAN_W'(1)));
  endfunction

  // first position of that window
  function automatic logic [POS_W-1:0] level_start(logic [LV1_W-1:0] l,
                                                   logic [POS_W-1:0] p);
    return POS_W'(SPAN_W'(p) + SPAN_W'(1) - (SPAN_W'(1) << l));
  endfunction

  back_state_t              state;
  back_state_t              state_next;
  cmd_t                     q_cmd;
  cmd_t                     cmd;
  logic [LVL_W-1:0]         lvl;
  logic [LV1_W-1:0]         lvl_inc;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] read_min;
  logic [DATA_W-1:0]        mem [MEM_DEPTH];
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0]        raddr;
  logic                     out_free;
  logic                     fits_first;
  logic                     fits_next;

  assign q_cmd      = cmd_t'(cmd_data);
  assign lvl_inc    = {1'b0, lvl} + LV1_W'(1);
  assign read_min   = (rdata < cur) ? rdata : cur;
  assign out_free   = !out_valid || out_ready;
  assign fits_first = level_fits(LV1_W'(1), q_cmd.pos_a);
  assign fits_next  = level_fits(lvl_inc, cmd.pos_a);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (q_cmd.kind)
            CMD_APPEND: state_next = fits_first ? B_APPEND : B_EMIT;
            CMD_QUERY:  state_next = B_QUERY_A;
            default:    state_next = B_EMIT;
          endcase
        end
      end
      B_APPEND:  state_next = fits_next ? B_APPEND : B_EMIT;
      B_QUERY_A: state_next = B_QUERY_B;
      B_QUERY_B: state_next = B_EMIT;
      B_EMIT:    state_next = out_free ? B_IDLE : B_EMIT;
      default:   state_next = B_IDLE;
    endcase
  end

  // queue pop and memory port controls
  always_comb begin
    cmd_ready = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && q_cmd.kind == CMD_APPEND) begin
          we    = 1'b1;
          waddr = {LVL_W'(0), q_cmd.pos_a};
          wdata = $signed(q_cmd.value);
          raddr = {LVL_W'(0), level_start(LV1_W'(1), q_cmd.pos_a)};
        end else begin
          raddr = {q_cmd.lvl, q_cmd.pos_a};
        end
      end
      B_APPEND: begin
        // write this level, fetch the lower half for the next one
        we    = 1'b1;
        waddr = {lvl, level_start({1'b0, lvl}, cmd.pos_a)};
        wdata = read_min;
        raddr = {lvl, level_start(lvl_inc, cmd.pos_a)};
      end
      B_QUERY_A: begin
        raddr = {cmd.lvl, cmd.pos_b};
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // window memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd <= q_cmd;
          lvl <= LVL_W'(1);
          cur <= $signed(q_cmd.value);
        end
      end
      B_APPEND: begin
        cur <= read_min;
        lvl <= LVL_W'(lvl_inc);
      end
      B_QUERY_A: begin
        cur <= rdata;
      end
      B_QUERY_B: begin
        cur <= read_min;
      end
      B_EMIT: begin
        if (out_free) begin
          min_value <= (cmd.kind == CMD_QUERY) ? cur : '0;
          status    <= cmd.status;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  `RMST_ASSERT_NEXT(a_query_min, clk, rst, state == B_QUERY_B,
    cur <= $past(rdata) && cur <= $past(cur), "query minimum above a window")
  `RMST_ASSERT_NEXT(a_emit_loads, clk, rst, state == B_EMIT && out_free,
    out_valid && state == B_IDLE, "result not loaded on emit")
  `RMST_ASSERT(a_append_level, clk, rst, state != B_APPEND || lvl != '0,
    "level zero reached the fill loop")

endmodule

`default_nettype wire

### design/range_minimum_sparse_table_unit.sv
`default_nettype none

// Sparse-table range-minimum engine. Each request is an append of a signed
// 32-bit value, a minimum query over the 1-based inclusive range
// [left_index, right_index], a clear or a no-op, and each one returns exactly
// one result (min_value is zero for everything but a good query; status flags
// a bad range or an append to a full table). A front end classifies requests
// and keeps the element count; a two-entry queue hands work to a back end
// that owns the single window memory (one write and one registered read per
// cycle). An append writes level 0 and then fills one higher level per cycle,
// up to level min(floor(log2(position + 1)), LEVELS - 1); a query makes two
// memory reads. The queue registers each command but lets new requests in
// while the back end is busy or a result waits on out_ready. Unwritten memory
// needs no clearing after reset.
module range_minimum_sparse_table_unit import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEVELS       = DEF_LEVELS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] value_in,
  input  logic [IDX_W-1:0]         left_index,
  input  logic [IDX_W-1:0]         right_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] min_value,
  output logic [STAT_W-1:0]        status
);

  localparam int POS_W = pos_width(MAX_ELEMENTS);
  localparam int LVL_W = $clog2(LEVELS);
  localparam int CMD_W = cmd_width(POS_W, LVL_W);

  logic             f_valid;
  logic             f_ready;
  logic [CMD_W-1:0] f_data;
  logic             b_valid;
  logic             b_ready;
  logic [CMD_W-1:0] b_data;

  rmst_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .value_in    (value_in),
    .left_index  (left_index),
    .right_index (right_index),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd_data    (f_data)
  );

  rmst_queue #(
    .WIDTH (CMD_W),
    .DEPTH (DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  rmst_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_value (min_value),
    .status    (status)
  );

endmodule

`default_nettype wire
